[rtl/swcp_pkg.sv]
// ----------------------------------------------------------------------------
// swcp_pkg
// shared types, constants and helper functions for the serial write command
// parser
// ----------------------------------------------------------------------------
`default_nettype none

package swcp_pkg;

    // longest line kept, in characters; later bytes up to the newline drop
    localparam int LINE_LIMIT = 254;
    localparam int LINE_POS_W = $clog2(LINE_LIMIT + 1);

    localparam int PING_LEN  = 4;
    localparam int WRITE_LEN = 6;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_X       = 8'h78;  // 'x'
    localparam logic [7:0] CHAR_B       = 8'h62;  // 'b'
    localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'

    typedef enum logic [2:0] {
        PH_KEYWORD,
        PH_ADDR,
        PH_VALUE,
        PH_WDONE,
        PH_PINGOK,
        PH_FAIL
    } t_phase;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_HEX,
        BASE_BIN
    } t_base;

    // digit position: 0 = nothing yet, 1 = leading zero seen, 2 = in number
    localparam logic [1:0] DPOS_START = 2'd0;
    localparam logic [1:0] DPOS_ZERO  = 2'd1;
    localparam logic [1:0] DPOS_BODY  = 2'd2;

    typedef struct packed {
        logic       reply_error;
        logic       write_valid;
        logic [7:0] write_addr;
        logic [7:0] write_data;
    } t_reply;

    typedef struct packed {
        logic       ended;
        t_base      base;
        logic [1:0] dpos;
        logic [7:0] acc;
    } t_num_step;

    function automatic logic [7:0] ping_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h50;  // P
            2'd1:    ch = 8'h49;  // I
            2'd2:    ch = 8'h4e;  // N
            default: ch = 8'h47;  // G
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] write_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h57;  // W
            3'd1:    ch = 8'h52;  // R
            3'd2:    ch = 8'h49;  // I
            3'd3:    ch = 8'h54;  // T
            3'd4:    ch = 8'h45;  // E
            default: ch = 8'h20;  // space
        endcase
        return ch;
    endfunction

    // a byte into the number; ended set on a non-digit, save x/b after a 0
    function automatic t_num_step num_step(input logic [7:0] c, input t_base base,
                                           input logic [1:0] dpos,
                                           input logic [7:0] acc);
        t_num_step  res;
        logic       is_digit;
        logic [3:0] d;
        logic [7:0] scaled;
        res.ended = 1'b0;
        res.base  = base;
        res.dpos  = dpos;
        res.acc   = acc;
        is_digit  = 1'b1;
        d         = 4'd0;
        case (c) inside
            [8'h30:8'h39]: d = 4'(c - 8'h30);
            [8'h61:8'h66]: d = 4'(c - 8'h57);
            [8'h41:8'h46]: d = 4'(c - 8'h37);
            default:       is_digit = 1'b0;
        endcase
        case (base)
            BASE_HEX: scaled = {acc[3:0], 4'b0};
            BASE_BIN: scaled = {acc[6:0], 1'b0};
            default:  scaled = {acc[4:0], 3'b0} + {acc[6:0], 1'b0};
        endcase
        if (dpos == DPOS_ZERO && (c == CHAR_X || c == CHAR_B)) begin
            res.base = (c == CHAR_X) ? BASE_HEX : BASE_BIN;
            res.acc  = 8'd0;
            res.dpos = DPOS_BODY;
        end else if (!is_digit) begin
            res.ended = 1'b1;
        end else begin
            res.acc  = scaled + {4'b0, d};
            res.dpos = (dpos == DPOS_START && c == CHAR_ZERO) ? DPOS_ZERO : DPOS_BODY;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/swcp_if.sv]
// ----------------------------------------------------------------------------
// swcp channel interfaces
// valid/ready channels for received bytes and for line replies
// ----------------------------------------------------------------------------
`default_nettype none

interface swcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface swcp_reply_if;
    logic       valid;
    logic       ready;
    logic       reply_error;
    logic       write_valid;
    logic [7:0] write_addr;
    logic [7:0] write_data;

    modport source (output valid, output reply_error, output write_valid,
                    output write_addr, output write_data, input ready);
    modport sink   (input valid, input reply_error, input write_valid,
                    input write_addr, input write_data, output ready);
endinterface

`default_nettype wire

[rtl/swcp_core.sv]
// ----------------------------------------------------------------------------
// swcp_core
// line parse state and the one-step update for each received byte
// ----------------------------------------------------------------------------
`default_nettype none

module swcp_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic [7:0]         i_byte,
    output swcp_pkg::t_reply        o_reply
);

    swcp_pkg::t_phase                    r_phase, n_phase;
    logic [swcp_pkg::LINE_POS_W-1:0]     r_line_pos, n_line_pos;
    logic                                r_ping_match, n_ping_match;
    logic                                r_write_match, n_write_match;
    swcp_pkg::t_base                     r_base, n_base;
    logic [1:0]                          r_dpos, n_dpos;
    logic [7:0]                          r_addr_acc, n_addr_acc;
    logic [7:0]                          r_value_acc, n_value_acc;

    swcp_pkg::t_num_step                 num;
    logic                                ping_hit, write_hit, ping_len_ok;

    always_comb begin
        num = swcp_pkg::num_step(i_byte, r_base, r_dpos,
                                 (r_phase == swcp_pkg::PH_ADDR) ? r_addr_acc
                                                                : r_value_acc);
        ping_len_ok = (r_line_pos == swcp_pkg::LINE_POS_W'(swcp_pkg::PING_LEN));
        ping_hit  = (r_line_pos < swcp_pkg::LINE_POS_W'(swcp_pkg::PING_LEN)) &&
                    (i_byte == swcp_pkg::ping_char(r_line_pos[1:0]));
        write_hit = (r_line_pos < swcp_pkg::LINE_POS_W'(swcp_pkg::WRITE_LEN)) &&
                    (i_byte == swcp_pkg::write_char(r_line_pos[2:0]));

        n_phase       = r_phase;
        n_line_pos    = r_line_pos;
        n_ping_match  = r_ping_match;
        n_write_match = r_write_match;
        n_base        = r_base;
        n_dpos        = r_dpos;
        n_addr_acc    = r_addr_acc;
        n_value_acc   = r_value_acc;

        o_reply.reply_error = 1'b1;
        o_reply.write_valid = 1'b0;
        o_reply.write_addr  = 8'd0;
        o_reply.write_data  = 8'd0;

        if (i_byte == swcp_pkg::CHAR_NEWLINE) begin
            case (r_phase)
                swcp_pkg::PH_KEYWORD: begin
                    o_reply.reply_error = !(r_ping_match && ping_len_ok);
                end
                swcp_pkg::PH_ADDR, swcp_pkg::PH_VALUE, swcp_pkg::PH_WDONE: begin
                    o_reply.reply_error = 1'b0;
                    o_reply.write_valid = 1'b1;
                    o_reply.write_addr  = r_addr_acc;
                    o_reply.write_data  = r_value_acc;
                end
                swcp_pkg::PH_PINGOK: begin
                    o_reply.reply_error = 1'b0;
                end
                default: begin
                    o_reply.reply_error = 1'b1;
                end
            endcase
            // back to the start of a line
            n_phase       = swcp_pkg::PH_KEYWORD;
            n_line_pos    = '0;
            n_ping_match  = 1'b1;
            n_write_match = 1'b1;
            n_base        = swcp_pkg::BASE_DEC;
            n_dpos        = swcp_pkg::DPOS_START;
            n_addr_acc    = 8'd0;
            n_value_acc   = 8'd0;
        end else if (r_line_pos < swcp_pkg::LINE_POS_W'(swcp_pkg::LINE_LIMIT)) begin
            n_line_pos = r_line_pos + swcp_pkg::LINE_POS_W'(1);
            case (r_phase)
                swcp_pkg::PH_KEYWORD: begin
                    if (i_byte == swcp_pkg::CHAR_NUL) begin
                        n_phase = (r_ping_match && ping_len_ok) ? swcp_pkg::PH_PINGOK
                                                                : swcp_pkg::PH_FAIL;
                    end else begin
                        n_ping_match  = r_ping_match && ping_hit;
                        n_write_match = r_write_match && write_hit;
                        if (n_write_match && r_line_pos ==
                                swcp_pkg::LINE_POS_W'(swcp_pkg::WRITE_LEN - 1)) begin
                            n_phase = swcp_pkg::PH_ADDR;
                            n_base  = swcp_pkg::BASE_DEC;
                            n_dpos  = swcp_pkg::DPOS_START;
                        end else if (!n_ping_match && !n_write_match) begin
                            n_phase = swcp_pkg::PH_FAIL;
                        end
                    end
                end
                swcp_pkg::PH_ADDR: begin
                    if (i_byte == swcp_pkg::CHAR_NUL) begin
                        n_phase = swcp_pkg::PH_WDONE;
                    end else if (num.ended) begin
                        // terminator is skipped, value starts fresh
                        n_phase = swcp_pkg::PH_VALUE;
                        n_base  = swcp_pkg::BASE_DEC;
                        n_dpos  = swcp_pkg::DPOS_START;
                    end else begin
                        n_base     = num.base;
                        n_dpos     = num.dpos;
                        n_addr_acc = num.acc;
                    end
                end
                swcp_pkg::PH_VALUE: begin
                    if (i_byte == swcp_pkg::CHAR_NUL || num.ended) begin
                        n_phase = swcp_pkg::PH_WDONE;
                    end else begin
                        n_base      = num.base;
                        n_dpos      = num.dpos;
                        n_value_acc = num.acc;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= swcp_pkg::PH_KEYWORD;
            r_line_pos    <= '0;
            r_ping_match  <= 1'b1;
            r_write_match <= 1'b1;
            r_base        <= swcp_pkg::BASE_DEC;
            r_dpos        <= swcp_pkg::DPOS_START;
            r_addr_acc    <= 8'd0;
            r_value_acc   <= 8'd0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_line_pos    <= n_line_pos;
            r_ping_match  <= n_ping_match;
            r_write_match <= n_write_match;
            r_base        <= n_base;
            r_dpos        <= n_dpos;
            r_addr_acc    <= n_addr_acc;
            r_value_acc   <= n_value_acc;
        end
    end

endmodule

`default_nettype wire

[rtl/serial_write_command_parser_unit.sv]
// a newline passes from the input register through the parse step
// into the output register, which raises its reply
// throughput: one byte per cycle, sustained, while replies are taken
// a stalled reply holds the output register; non-newline bytes keep flowing meanwhile
// reset (synchronous, active low) empties both registers and returns to line start
// ----------------------------------------------------------------------------
// serial_write_command_parser_unit
// line parser for a serial byte stream: PING and WRITE <addr> <value> commands
// ----------------------------------------------------------------------------
`default_nettype none

module serial_write_command_parser_unit (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    swcp_byte_if.sink    i_rx,
    swcp_reply_if.source o_reply
);

    // input register: one byte waiting for the parse step
    logic                r_in_valid, n_in_valid;
    logic [7:0]          r_in_byte;

    // output register: one finished reply
    logic                r_out_valid, n_out_valid;
    swcp_pkg::t_reply    r_out_reply;

    swcp_pkg::t_reply    step_reply;
    logic                is_newline;
    logic                out_free;
    logic                step;
    logic                in_take;

    // the output register frees up either when empty or when taken this cycle
    assign out_free   = !r_out_valid || o_reply.ready;
    assign is_newline = (r_in_byte == swcp_pkg::CHAR_NEWLINE);
    // only a newline needs room in the output register
    assign step       = r_in_valid && (!is_newline || out_free);
    assign i_rx.ready = !r_in_valid || step;
    assign in_take    = i_rx.valid && i_rx.ready;

    swcp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_reply (step_reply)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (step) begin
            n_in_valid = 1'b0;
        end
        if (in_take) begin
            n_in_valid = 1'b1;
        end
        if (r_out_valid && o_reply.ready) begin
            n_out_valid = 1'b0;
        end
        if (step && is_newline) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (step && is_newline) begin
            r_out_reply <= step_reply;
        end
    end

    assign o_reply.valid       = r_out_valid;
    assign o_reply.reply_error = r_out_reply.reply_error;
    assign o_reply.write_valid = r_out_reply.write_valid;
    assign o_reply.write_addr  = r_out_reply.write_addr;
    assign o_reply.write_data  = r_out_reply.write_data;

endmodule

`default_nettype wire

[rtl/swcp_checker.sv]
// ----------------------------------------------------------------------------
// swcp_checker
// port-level checks on the reply channel of the parser
// ----------------------------------------------------------------------------
`default_nettype none

module swcp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_reply_error,
    input wire logic       i_write_valid,
    input wire logic [7:0] i_write_addr,
    input wire logic [7:0] i_write_data
);

    // a stalled reply stays up
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("reply dropped while stalled");

    // a stalled reply keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_reply_error) && $stable(i_write_valid) &&
            $stable(i_write_addr) && $stable(i_write_data))
        else $error("reply payload changed while stalled");

    // a write request always answers ok
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_write_valid |-> !i_reply_error)
        else $error("write request with error reply");

    // no write: address and data read zero
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_write_valid |-> i_write_addr == 8'd0 && i_write_data == 8'd0)
        else $error("nonzero write fields without write request");

    // nothing can be ready to leave right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("reply valid right after reset");

endmodule

bind serial_write_command_parser_unit swcp_checker u_swcp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_reply.valid),
    .i_out_ready   (o_reply.ready),
    .i_reply_error (o_reply.reply_error),
    .i_write_valid (o_reply.write_valid),
    .i_write_addr  (o_reply.write_addr),
    .i_write_data  (o_reply.write_data)
);

`default_nettype wire
